// ----- src/deq_pkg.sv -----
// Shared types and constants for the double-ended queue.
// Used by deq_ctrl, deq_datapath and the top level double_ended_queue.
package deq_pkg;

    localparam int DEPTH = 16;
    localparam int WIDTH = 32;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    // Port field widths
    localparam int OP_W     = 3;
    localparam int VALUE_W  = 32;
    localparam int OUT_W    = 32;
    localparam int COUNT_W  = 5;
    localparam int STATUS_W = 2;
    localparam int M_DATA_W = 72;
    localparam int M_USER_W = 4;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_CLEAR      = 3'd4
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE      = 2'd0,
        ST_POP_EMPTY = 2'd1,
        ST_PUSH_FULL = 2'd2
    } status_t;

    typedef struct packed {
        logic update;
        logic fetch;
        logic load;
    } deq_cmd_t;

endpackage

// ----- src/double_ended_queue.sv -----
// Bounded double-ended queue, top level.
// Joins the sequencer deq_ctrl and the datapath deq_datapath; depends on deq_pkg.
//
// Usage:
//   Slave channel: one request per accepted beat (s_tvalid & s_tready).
//   s_tuser carries the operation (push front, push back, pop front,
//   pop back, clear); s_tdata carries the word to push.
//   Master channel: one result per request, giving the words at both ends,
//   the count, the full flag and a status (done, pop on empty ignored,
//   push on full dropped).
//   Steps: the store is written at acceptance, both ends are read from the
//   registered two-port read of the store in the next cycle, and the result
//   register is loaded from them once it is free, which raises m_tvalid;
//   s_tready is high again after that.
//   A new request is accepted while an earlier result still waits; if the
//   receiver stalls, the sequencer holds the fetched ends until the result
//   register is taken.
//   Reset clears the count and front pointer (empty queue) and drops any
//   pending result; the word store itself is not cleared.
module double_ended_queue
    import deq_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [VALUE_W-1:0]  s_tdata,   // [31:0] value
    input  logic [OP_W-1:0]     s_tuser,   // [2:0] operation
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // [31:0] front_value, [63:32] back_value,
                                           // [68:64] count, [71:69] zero
    output logic [M_USER_W-1:0] m_tuser    // [0] ends_valid, [1] is_full, [3:2] status
);

    deq_cmd_t            cmd;
    logic                out_free;
    logic [OUT_W-1:0]    front_value;
    logic [OUT_W-1:0]    back_value;
    logic                ends_valid;
    logic [COUNT_W-1:0]  count;
    logic                is_full;
    logic [STATUS_W-1:0] status;

    deq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .out_free (out_free),
        .cmd      (cmd)
    );

    deq_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .op_in       (s_tuser),
        .value_in    (s_tdata),
        .out_free    (out_free),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .front_value (front_value),
        .back_value  (back_value),
        .ends_valid  (ends_valid),
        .count       (count),
        .is_full     (is_full),
        .status      (status)
    );

    assign m_tdata = {(M_DATA_W - 2*OUT_W - COUNT_W)'(0), count, back_value, front_value};
    assign m_tuser = {status, is_full, ends_valid};

endmodule

// ----- src/deq_ctrl.sv -----
// Sequencer for the double-ended queue: accept a request, fetch both ends,
// then load the result register. Depends on deq_pkg.
module deq_ctrl
    import deq_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  logic     out_free,
    output deq_cmd_t cmd
);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_FETCH = 3'b010,
        S_LOAD  = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.update = in_valid;
                if (in_valid)
                begin
                    state_next = S_FETCH;
                end
            end
            S_FETCH:
            begin
                cmd.fetch  = 1'b1;
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                // hold the fetched ends until the result register is free
                if (out_free)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ----- src/deq_datapath.sv -----
// Datapath of the double-ended queue: ring store, front pointer, count,
// end-word read registers and the result register. Depends on deq_pkg.
module deq_datapath
    import deq_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  deq_cmd_t            cmd,
    input  logic [OP_W-1:0]     op_in,
    input  logic [VALUE_W-1:0]  value_in,
    output logic                out_free,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [OUT_W-1:0]    front_value,
    output logic [OUT_W-1:0]    back_value,
    output logic                ends_valid,
    output logic [COUNT_W-1:0]  count,
    output logic                is_full,
    output logic [STATUS_W-1:0] status
);

    localparam logic [PTR_W:0]   DEPTH_EXT = (PTR_W + 1)'(DEPTH);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);

    function automatic logic [PTR_W-1:0] ring_add(input logic [PTR_W-1:0] base,
                                                  input logic [PTR_W-1:0] offset);
        logic [PTR_W:0] sum;
        sum = {1'b0, base} + {1'b0, offset};
        if (sum >= DEPTH_EXT)
        begin
            sum = sum - DEPTH_EXT;
        end
        return sum[PTR_W-1:0];
    endfunction

    logic [WIDTH-1:0] mem [DEPTH];

    logic [PTR_W-1:0]    front_ptr_reg, front_ptr_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    status_t             status_reg, status_next;
    logic [WIDTH-1:0]    rd_front_reg, rd_back_reg;
    logic                m_valid_reg;
    logic [OUT_W-1:0]    m_front_reg, m_back_reg;
    logic                m_ends_reg, m_full_reg;
    logic [COUNT_W-1:0]  m_count_reg;
    status_t             m_status_reg;

    op_t              op;
    logic             full;
    logic             empty;
    logic             wr_en;
    logic [PTR_W-1:0] wr_addr;
    logic [PTR_W-1:0] back_addr;
    logic [WIDTH-1:0] wr_word;
    logic [CNT_W-1:0] count_less;

    assign op      = op_t'(op_in);
    assign full    = (count_reg == DEPTH_CNT);
    assign empty   = (count_reg == '0);
    assign wr_word = WIDTH'(value_in);

    assign count_less = count_reg - CNT_W'(1);
    assign back_addr  = ring_add(front_ptr_reg, count_less[PTR_W-1:0]);

    always_comb
    begin
        front_ptr_next = front_ptr_reg;
        count_next     = count_reg;
        status_next    = ST_DONE;
        wr_en          = 1'b0;
        wr_addr        = ring_add(front_ptr_reg, count_reg[PTR_W-1:0]);
        unique case (op)
            OP_PUSH_FRONT:
            begin
                if (full)
                begin
                    status_next = ST_PUSH_FULL;
                end
                else
                begin
                    front_ptr_next = (front_ptr_reg == '0) ? LAST_SLOT
                                                          : front_ptr_reg - PTR_W'(1);
                    wr_addr        = front_ptr_next;
                    wr_en          = 1'b1;
                    count_next     = count_reg + CNT_W'(1);
                end
            end
            OP_PUSH_BACK:
            begin
                if (full)
                begin
                    status_next = ST_PUSH_FULL;
                end
                else
                begin
                    wr_en      = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            OP_POP_FRONT:
            begin
                if (empty)
                begin
                    status_next = ST_POP_EMPTY;
                end
                else
                begin
                    front_ptr_next = (front_ptr_reg == LAST_SLOT) ? '0
                                                                 : front_ptr_reg + PTR_W'(1);
                    count_next     = count_less;
                end
            end
            OP_POP_BACK:
            begin
                if (empty)
                begin
                    status_next = ST_POP_EMPTY;
                end
                else
                begin
                    count_next = count_less;
                end
            end
            OP_CLEAR:
            begin
                front_ptr_next = '0;
                count_next     = '0;
            end
            default:
            begin
                // unused codes leave the queue as it is
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_ptr_reg <= '0;
            count_reg     <= '0;
            status_reg    <= ST_DONE;
        end
        else if (cmd.update)
        begin
            front_ptr_reg <= front_ptr_next;
            count_reg     <= count_next;
            status_reg    <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.update && wr_en)
        begin
            mem[wr_addr] <= wr_word;
        end
        if (cmd.fetch)
        begin
            rd_front_reg <= mem[front_ptr_reg];
            rd_back_reg  <= mem[back_addr];
        end
    end

    assign out_free = !m_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            // an empty queue reports zero at both ends
            m_front_reg  <= empty ? '0 : OUT_W'(rd_front_reg);
            m_back_reg   <= empty ? '0 : OUT_W'(rd_back_reg);
            m_ends_reg   <= !empty;
            m_count_reg  <= COUNT_W'(count_reg);
            m_full_reg   <= full;
            m_status_reg <= status_reg;
        end
    end

    assign out_valid   = m_valid_reg;
    assign front_value = m_front_reg;
    assign back_value  = m_back_reg;
    assign ends_valid  = m_ends_reg;
    assign count       = m_count_reg;
    assign is_full     = m_full_reg;
    assign status      = m_status_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_CNT)
        else $error("word count exceeds depth");

    a_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, front_ptr_reg} < DEPTH_EXT)
        else $error("front pointer outside the ring");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> out_free)
        else $error("result loaded over a pending result");

    a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.update && full && (op == OP_PUSH_FRONT || op == OP_PUSH_BACK))
        |=> (count_reg == $past(count_reg)) && (front_ptr_reg == $past(front_ptr_reg))
            && (status_reg == ST_PUSH_FULL))
        else $error("push on full queue changed state");

endmodule
